@@ src/pcsm_pkg.sv @@
`default_nettype none

package pcsm_pkg;

	// Sizes of the machine.
	localparam int STACK_DEPTH = 512;
	localparam int CODE_DEPTH = 256;
	localparam int MAX_LEVEL = 3;
	localparam int WORD_WIDTH = 32;

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int PCW = $clog2(CODE_DEPTH);
	localparam int LVW = $clog2(MAX_LEVEL + 1);
	localparam int OPC_W = 3;
	localparam int LEV_W = 2;
	localparam int OPD_W = 11;
	localparam int ERR_W = 2;
	localparam int IDX_W = 9;

	// Instruction opcodes.
	localparam logic [OPC_W-1:0] OP_LIT = 3'd0;
	localparam logic [OPC_W-1:0] OP_OPR = 3'd1;
	localparam logic [OPC_W-1:0] OP_LOD = 3'd2;
	localparam logic [OPC_W-1:0] OP_STO = 3'd3;
	localparam logic [OPC_W-1:0] OP_CAL = 3'd4;
	localparam logic [OPC_W-1:0] OP_INT = 3'd5;
	localparam logic [OPC_W-1:0] OP_JMP = 3'd6;
	localparam logic [OPC_W-1:0] OP_JPC = 3'd7;

	// OPR function codes.
	localparam logic [OPD_W-1:0] OPR_RET = 11'd0;
	localparam logic [OPD_W-1:0] OPR_NEG = 11'd1;
	localparam logic [OPD_W-1:0] OPR_ADD = 11'd2;
	localparam logic [OPD_W-1:0] OPR_SUB = 11'd3;
	localparam logic [OPD_W-1:0] OPR_MUL = 11'd4;
	localparam logic [OPD_W-1:0] OPR_DIV = 11'd5;
	localparam logic [OPD_W-1:0] OPR_ODD = 11'd6;
	localparam logic [OPD_W-1:0] OPR_EQ = 11'd8;
	localparam logic [OPD_W-1:0] OPR_NE = 11'd9;
	localparam logic [OPD_W-1:0] OPR_LT = 11'd10;
	localparam logic [OPD_W-1:0] OPR_GE = 11'd11;
	localparam logic [OPD_W-1:0] OPR_GT = 11'd12;
	localparam logic [OPD_W-1:0] OPR_LE = 11'd13;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
	localparam logic [ERR_W-1:0] ERR_STACK = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OPR = 2'd3;

	// Datapath actions.
	localparam int ACT_W = 5;
	localparam logic [ACT_W-1:0] A_NOP = 5'd0;
	localparam logic [ACT_W-1:0] A_CLR = 5'd1;
	localparam logic [ACT_W-1:0] A_LOAD = 5'd2;
	localparam logic [ACT_W-1:0] A_LIT_W = 5'd3;
	localparam logic [ACT_W-1:0] A_INT_DO = 5'd4;
	localparam logic [ACT_W-1:0] A_JMP_DO = 5'd5;
	localparam logic [ACT_W-1:0] A_JPC_DO = 5'd6;
	localparam logic [ACT_W-1:0] A_CAP_X = 5'd7;
	localparam logic [ACT_W-1:0] A_CAP_Y = 5'd8;
	localparam logic [ACT_W-1:0] A_RET_DO = 5'd9;
	localparam logic [ACT_W-1:0] A_UN_DO = 5'd10;
	localparam logic [ACT_W-1:0] A_ALU = 5'd11;
	localparam logic [ACT_W-1:0] A_DIV_GO = 5'd12;
	localparam logic [ACT_W-1:0] A_DIV_CAP = 5'd13;
	localparam logic [ACT_W-1:0] A_BIN_W = 5'd14;
	localparam logic [ACT_W-1:0] A_LINK = 5'd15;
	localparam logic [ACT_W-1:0] A_LOD_W = 5'd16;
	localparam logic [ACT_W-1:0] A_STO_W = 5'd17;
	localparam logic [ACT_W-1:0] A_CAL_W1 = 5'd18;
	localparam logic [ACT_W-1:0] A_CAL_W2 = 5'd19;
	localparam logic [ACT_W-1:0] A_CAL_W3 = 5'd20;
	localparam logic [ACT_W-1:0] A_ERR1 = 5'd21;
	localparam logic [ACT_W-1:0] A_ERR2 = 5'd22;
	localparam logic [ACT_W-1:0] A_ERR3 = 5'd23;
	localparam logic [ACT_W-1:0] A_FIN_OUT = 5'd24;

	// Stack read address sources.
	localparam int RD_W = 3;
	localparam logic [RD_W-1:0] R_T = 3'd0;
	localparam logic [RD_W-1:0] R_TM1 = 3'd1;
	localparam logic [RD_W-1:0] R_BP1 = 3'd2;
	localparam logic [RD_W-1:0] R_BP2 = 3'd3;
	localparam logic [RD_W-1:0] R_BASE = 3'd4;
	localparam logic [RD_W-1:0] R_ADDR = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [RD_W-1:0] rd;
	} pcsm_cmd_t;

	typedef struct packed {
		logic halted;
		logic [OPC_W-1:0] op;
		logic opr_ret;
		logic opr_un;
		logic opr_bin;
		logic opr_div;
		logic push_ok;
		logic int_ok;
		logic t_ge1;
		logic ret_ok;
		logic cal_ok;
		logic addr_ok;
		logic n_zero;
		logic link_bad;
		logic y_zero;
		logic div_done;
		logic out_free;
		logic clr_last;
	} pcsm_stat_t;

endpackage

`default_nettype wire

@@ src/pcsm_div.sv @@
`default_nettype none

module pcsm_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pcsm_pkg::WORD_WIDTH-1:0] dividend,
	input  wire logic [pcsm_pkg::WORD_WIDTH-1:0] divisor,
	output logic                                 done,
	output logic [pcsm_pkg::WORD_WIDTH-1:0]      quotient
);
	import pcsm_pkg::*;

	localparam int CW = $clog2(WORD_WIDTH + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [WORD_WIDTH-1:0] quo_q;
	logic [WORD_WIDTH-1:0] d_q;
	logic [WORD_WIDTH:0]   shifted;
	logic [WORD_WIDTH:0]   diff;
	logic [WORD_WIDTH-1:0] mag_x;
	logic [WORD_WIDTH-1:0] mag_y;

	// Operand magnitudes and one restoring step.
	assign mag_x = dividend[WORD_WIDTH-1] ? -dividend : dividend;
	assign mag_y = divisor[WORD_WIDTH-1] ? -divisor : divisor;
	assign shifted = {rem_q, quo_q[WORD_WIDTH-1]};
	assign diff = shifted - {1'b0, d_q};

	// Step counter, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WORD_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
			rem_q <= '0;
			quo_q <= mag_x;
			d_q <= mag_y;
		end else if (busy_q) begin
			if (!diff[WORD_WIDTH]) begin
				rem_q <= diff[WORD_WIDTH-1:0];
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_WIDTH-1:0];
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

`default_nettype wire

@@ src/pcsm_ctrl.sv @@
`default_nettype none

module pcsm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pcsm_pkg::pcsm_stat_t stat,
	output pcsm_pkg::pcsm_cmd_t       cmd
);
	import pcsm_pkg::*;

	localparam int SW = 5;
	localparam logic [SW-1:0] S_CLEAR = 5'd0;
	localparam logic [SW-1:0] S_IDLE = 5'd1;
	localparam logic [SW-1:0] S_DISP = 5'd2;
	localparam logic [SW-1:0] S_JPC2 = 5'd3;
	localparam logic [SW-1:0] S_RET1 = 5'd4;
	localparam logic [SW-1:0] S_RET2 = 5'd5;
	localparam logic [SW-1:0] S_UN2 = 5'd6;
	localparam logic [SW-1:0] S_BIN1 = 5'd7;
	localparam logic [SW-1:0] S_BIN2 = 5'd8;
	localparam logic [SW-1:0] S_BIN3 = 5'd9;
	localparam logic [SW-1:0] S_DIVW = 5'd10;
	localparam logic [SW-1:0] S_BINW = 5'd11;
	localparam logic [SW-1:0] S_WALK = 5'd12;
	localparam logic [SW-1:0] S_LINK = 5'd13;
	localparam logic [SW-1:0] S_POST = 5'd14;
	localparam logic [SW-1:0] S_LOD2 = 5'd15;
	localparam logic [SW-1:0] S_STO2 = 5'd16;
	localparam logic [SW-1:0] S_CAL2 = 5'd17;
	localparam logic [SW-1:0] S_CAL3 = 5'd18;
	localparam logic [SW-1:0] S_FIN = 5'd19;
	localparam logic [SW-1:0] S_OUT = 5'd20;

	logic [SW-1:0] state_q;
	logic [SW-1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Sequencing of one instruction.
	always_comb begin
		state_d = state_q;
		cmd.act = A_NOP;
		cmd.rd = R_T;
		unique case (state_q)
			S_CLEAR: begin
				cmd.act = A_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = A_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				if (!stat.halted) begin
					unique case (stat.op)
						OP_LIT: cmd.act = stat.push_ok ? A_LIT_W : A_ERR2;
						OP_INT: cmd.act = stat.int_ok ? A_INT_DO : A_ERR2;
						OP_JMP: cmd.act = A_JMP_DO;
						OP_JPC: begin
							if (stat.t_ge1) state_d = S_JPC2;
							else cmd.act = A_ERR2;
						end
						OP_OPR: begin
							priority if (stat.opr_ret) begin
								if (stat.ret_ok) begin
									cmd.rd = R_BP1;
									state_d = S_RET1;
								end else cmd.act = A_ERR2;
							end else if (stat.opr_un) begin
								state_d = S_UN2;
							end else if (stat.opr_bin) begin
								if (stat.t_ge1) begin
									cmd.rd = R_TM1;
									state_d = S_BIN1;
								end else cmd.act = A_ERR2;
							end else begin
								cmd.act = A_ERR3;
							end
						end
						default: state_d = S_WALK;
					endcase
				end
			end
			S_JPC2: begin
				cmd.act = A_JPC_DO;
				state_d = S_FIN;
			end
			S_RET1: begin
				cmd.act = A_CAP_X;
				cmd.rd = R_BP2;
				state_d = S_RET2;
			end
			S_RET2: begin
				cmd.act = A_RET_DO;
				state_d = S_FIN;
			end
			S_UN2: begin
				cmd.act = A_UN_DO;
				state_d = S_FIN;
			end
			S_BIN1: begin
				cmd.act = A_CAP_X;
				state_d = S_BIN2;
			end
			S_BIN2: begin
				cmd.act = A_CAP_Y;
				state_d = S_BIN3;
			end
			S_BIN3: begin
				priority if (!stat.opr_div) begin
					cmd.act = A_ALU;
					state_d = S_BINW;
				end else if (stat.y_zero) begin
					cmd.act = A_ERR1;
					state_d = S_FIN;
				end else begin
					cmd.act = A_DIV_GO;
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.act = A_DIV_CAP;
					state_d = S_BINW;
				end
			end
			S_BINW: begin
				cmd.act = A_BIN_W;
				state_d = S_FIN;
			end
			S_WALK: begin
				if (stat.n_zero) begin
					state_d = S_POST;
				end else begin
					cmd.rd = R_BASE;
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				if (stat.link_bad) begin
					cmd.act = A_ERR2;
					state_d = S_FIN;
				end else begin
					cmd.act = A_LINK;
					state_d = S_WALK;
				end
			end
			S_POST: begin
				state_d = S_FIN;
				priority if (stat.op == OP_LOD) begin
					if (stat.addr_ok && stat.push_ok) begin
						cmd.rd = R_ADDR;
						state_d = S_LOD2;
					end else cmd.act = A_ERR2;
				end else if (stat.op == OP_STO) begin
					if (stat.addr_ok && stat.t_ge1) state_d = S_STO2;
					else cmd.act = A_ERR2;
				end else begin
					if (stat.cal_ok) begin
						cmd.act = A_CAL_W1;
						state_d = S_CAL2;
					end else cmd.act = A_ERR2;
				end
			end
			S_LOD2: begin
				cmd.act = A_LOD_W;
				state_d = S_FIN;
			end
			S_STO2: begin
				cmd.act = A_STO_W;
				state_d = S_FIN;
			end
			S_CAL2: begin
				cmd.act = A_CAL_W2;
				state_d = S_CAL3;
			end
			S_CAL3: begin
				cmd.act = A_CAL_W3;
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.act = A_FIN_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ src/pcsm_dp.sv @@
`default_nettype none

module pcsm_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire pcsm_pkg::pcsm_cmd_t                    cmd,
	output pcsm_pkg::pcsm_stat_t                        stat,
	input  wire logic [pcsm_pkg::OPC_W-1:0]             opcode,
	input  wire logic [pcsm_pkg::LEV_W-1:0]             level,
	input  wire logic [pcsm_pkg::OPD_W-1:0]             operand,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic [pcsm_pkg::PCW-1:0]                    next_pc,
	output logic [pcsm_pkg::IDX_W-1:0]                  top_index,
	output logic signed [pcsm_pkg::WORD_WIDTH-1:0]      top_value,
	output logic                                        halted,
	output logic [pcsm_pkg::ERR_W-1:0]                  error_code
);
	import pcsm_pkg::*;

	localparam int CHK_W = ((SAW > OPD_W) ? SAW : OPD_W) + 2;

	logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

	logic [SAW-1:0]        t_q;
	logic [SAW-1:0]        b_q;
	logic [PCW-1:0]        pc_q;
	logic                  halt_q;
	logic [SAW-1:0]        clr_q;
	logic                  out_valid_q;
	logic [OPC_W-1:0]      op_q;
	logic [OPD_W-1:0]      a_q;
	logic [PCW-1:0]        next_q;
	logic [SAW-1:0]        base_q;
	logic [LVW-1:0]        n_q;
	logic [WORD_WIDTH-1:0] x_q;
	logic [WORD_WIDTH-1:0] y_q;
	logic [WORD_WIDTH-1:0] res_q;
	logic [ERR_W-1:0]      err_q;
	logic [WORD_WIDTH-1:0] rdata_q;
	logic [PCW-1:0]        out_pc_q;
	logic [SAW-1:0]        out_top_q;
	logic [WORD_WIDTH-1:0] out_val_q;
	logic                  out_halt_q;
	logic [ERR_W-1:0]      out_err_q;

	logic [CHK_W-1:0]      t_c;
	logic [CHK_W-1:0]      addr_c;
	logic [SAW-1:0]        raddr;
	logic                  wr_en;
	logic [SAW-1:0]        wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [WORD_WIDTH-1:0] alu_res;
	logic                  div_done;
	logic [WORD_WIDTH-1:0] div_quo;
	logic                  rb_bad;

	// Range checks on stack addresses.
	assign t_c = CHK_W'(t_q);
	assign addr_c = CHK_W'(base_q) + CHK_W'(a_q);
	assign rb_bad = (x_q >> SAW) != '0;

	assign stat.halted = halt_q;
	assign stat.op = op_q;
	assign stat.opr_ret = (a_q == OPR_RET);
	assign stat.opr_un = (a_q == OPR_NEG) || (a_q == OPR_ODD);
	assign stat.opr_bin = ((a_q >= OPR_ADD) && (a_q <= OPR_DIV))
		|| ((a_q >= OPR_EQ) && (a_q <= OPR_LE));
	assign stat.opr_div = (a_q == OPR_DIV);
	assign stat.push_ok = (t_c + CHK_W'(1)) < CHK_W'(STACK_DEPTH);
	assign stat.int_ok = (t_c + CHK_W'(a_q)) < CHK_W'(STACK_DEPTH);
	assign stat.t_ge1 = (t_q != '0);
	assign stat.ret_ok = (b_q != '0) && ((CHK_W'(b_q) + CHK_W'(2)) < CHK_W'(STACK_DEPTH));
	assign stat.cal_ok = (t_c + CHK_W'(3)) < CHK_W'(STACK_DEPTH);
	assign stat.addr_ok = addr_c < CHK_W'(STACK_DEPTH);
	assign stat.n_zero = (n_q == '0);
	assign stat.link_bad = (rdata_q >> SAW) != '0;
	assign stat.y_zero = (y_q == '0);
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.clr_last = (clr_q == SAW'(STACK_DEPTH - 1));

	// Stack read address.
	always_comb begin
		unique case (cmd.rd)
			R_T:     raddr = t_q;
			R_TM1:   raddr = t_q - 1'b1;
			R_BP1:   raddr = b_q + 1'b1;
			R_BP2:   raddr = b_q + SAW'(2);
			R_BASE:  raddr = base_q;
			R_ADDR:  raddr = addr_c[SAW-1:0];
			default: raddr = t_q;
		endcase
	end

	// Stack write port.
	always_comb begin
		wr_en = 1'b1;
		wr_addr = t_q;
		wr_data = '0;
		unique case (cmd.act)
			A_CLR: wr_addr = clr_q;
			A_LIT_W: begin
				wr_addr = t_q + 1'b1;
				wr_data = WORD_WIDTH'(a_q);
			end
			A_UN_DO: wr_data = (a_q == OPR_NEG) ? -rdata_q
				: (rdata_q & WORD_WIDTH'(1));
			A_BIN_W: begin
				wr_addr = t_q - 1'b1;
				wr_data = res_q;
			end
			A_LOD_W: begin
				wr_addr = t_q + 1'b1;
				wr_data = rdata_q;
			end
			A_STO_W: begin
				wr_addr = addr_c[SAW-1:0];
				wr_data = rdata_q;
			end
			A_CAL_W1: begin
				wr_addr = t_q + 1'b1;
				wr_data = WORD_WIDTH'(base_q);
			end
			A_CAL_W2: begin
				wr_addr = t_q + SAW'(2);
				wr_data = WORD_WIDTH'(b_q);
			end
			A_CAL_W3: begin
				wr_addr = t_q + SAW'(3);
				wr_data = WORD_WIDTH'(next_q);
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Stack memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[raddr];
	end

	// Two-operand arithmetic and signed comparisons.
	always_comb begin
		unique case (a_q)
			OPR_ADD: alu_res = x_q + y_q;
			OPR_SUB: alu_res = x_q - y_q;
			OPR_MUL: alu_res = x_q * y_q;
			OPR_EQ:  alu_res = WORD_WIDTH'(x_q == y_q);
			OPR_NE:  alu_res = WORD_WIDTH'(x_q != y_q);
			OPR_LT:  alu_res = WORD_WIDTH'($signed(x_q) < $signed(y_q));
			OPR_GE:  alu_res = WORD_WIDTH'(!($signed(x_q) < $signed(y_q)));
			OPR_GT:  alu_res = WORD_WIDTH'($signed(y_q) < $signed(x_q));
			OPR_LE:  alu_res = WORD_WIDTH'(!($signed(y_q) < $signed(x_q)));
			default: alu_res = '0;
		endcase
	end

	pcsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.act == A_DIV_GO),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Machine state: top, frame base, pc, halt, clear sweep and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			b_q <= SAW'(1);
			pc_q <= '0;
			halt_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.act == A_FIN_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.act)
				A_CLR:    clr_q <= clr_q + 1'b1;
				A_LIT_W:  t_q <= t_q + 1'b1;
				A_INT_DO: t_q <= t_q + SAW'(a_q);
				A_JPC_DO: t_q <= t_q - 1'b1;
				A_RET_DO: begin
					if (!rb_bad) begin
						t_q <= b_q - 1'b1;
						b_q <= x_q[SAW-1:0];
					end
				end
				A_BIN_W:  t_q <= t_q - 1'b1;
				A_LOD_W:  t_q <= t_q + 1'b1;
				A_STO_W:  t_q <= t_q - 1'b1;
				A_CAL_W3: b_q <= t_q + 1'b1;
				A_FIN_OUT: begin
					if (!halt_q) begin
						pc_q <= next_q;
						halt_q <= (next_q == '0);
					end
				end
				default: ;
			endcase
		end
	end

	// Per-instruction working registers and the result word.
	always_ff @(posedge clk) begin
		unique case (cmd.act)
			A_LOAD: begin
				op_q <= opcode;
				a_q <= operand;
				base_q <= b_q;
				n_q <= (int'(level) > MAX_LEVEL) ? LVW'(MAX_LEVEL) : LVW'(level);
				next_q <= pc_q + 1'b1;
				err_q <= ERR_OK;
			end
			A_JMP_DO: next_q <= a_q[PCW-1:0];
			A_JPC_DO: begin
				if (rdata_q == '0) next_q <= a_q[PCW-1:0];
			end
			A_RET_DO: begin
				if (rb_bad) err_q <= ERR_STACK;
				else next_q <= rdata_q[PCW-1:0];
			end
			A_CAP_X:   x_q <= rdata_q;
			A_CAP_Y:   y_q <= rdata_q;
			A_ALU:     res_q <= alu_res;
			A_DIV_CAP: res_q <= div_quo;
			A_LINK: begin
				base_q <= rdata_q[SAW-1:0];
				n_q <= n_q - 1'b1;
			end
			A_CAL_W3: begin
				base_q <= base_q;
				next_q <= a_q[PCW-1:0];
			end
			A_ERR1: err_q <= ERR_DIV0;
			A_ERR2: err_q <= ERR_STACK;
			A_ERR3: err_q <= ERR_OPR;
			A_FIN_OUT: begin
				out_pc_q <= halt_q ? pc_q : next_q;
				out_top_q <= t_q;
				out_val_q <= rdata_q;
				out_halt_q <= halt_q || (next_q == '0);
				out_err_q <= err_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign next_pc = out_pc_q;
	assign top_index = IDX_W'(out_top_q);
	assign top_value = $signed(out_val_q);
	assign halted = out_halt_q;
	assign error_code = out_err_q;

`ifndef NO_ASSERTIONS
	// A result is only written into the output register when the slot is free.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == A_FIN_OUT) |-> (!out_valid || out_ready))
		else $error("result committed over an untaken word");

	// The pc moves only when a step is committed.
	a_pc_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act != A_FIN_OUT) |=> $stable(pc_q))
		else $error("pc changed outside commit");

	// Once halted the machine keeps its pc and stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> (halt_q && $stable(pc_q)))
		else $error("halted machine moved");

	// A divide result is only taken when the divider has finished.
	a_div_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == A_DIV_CAP) |-> div_done)
		else $error("quotient taken before divider finished");
`endif

endmodule

`default_nettype wire

@@ src/pcode_stack_machine.sv @@
// PL/0 p-code machine: each accepted word is one instruction (opcode, level,
// operand) and yields one result word (next pc, stack top index and value,
// halt flag, error code). After reset the block clears its whole stack memory
// before it takes the first instruction, and it takes no new instruction until
// the result word of the last one has been placed in the output register. LOD,
// STO and CAL follow one static link per level, and a divide waits for the
// one-bit-per-cycle divider.
// How long each instruction takes is set by the single read and single write
// port of the stack memory, which the sequencer uses for every stack access in
// turn. Once halted the machine only reports its state until the next reset.
`default_nettype none

module pcode_stack_machine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [pcsm_pkg::OPC_W-1:0]        opcode,
	input  wire logic [pcsm_pkg::LEV_W-1:0]        level,
	input  wire logic [pcsm_pkg::OPD_W-1:0]        operand,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [pcsm_pkg::PCW-1:0]               next_pc,
	output logic [pcsm_pkg::IDX_W-1:0]             top_index,
	output logic signed [pcsm_pkg::WORD_WIDTH-1:0] top_value,
	output logic                                   halted,
	output logic [pcsm_pkg::ERR_W-1:0]             error_code
);
	import pcsm_pkg::*;

	pcsm_cmd_t  cmd;
	pcsm_stat_t stat;

	// Sequencer.
	pcsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stack, registers and arithmetic.
	pcsm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (opcode),
		.level      (level),
		.operand    (operand),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.next_pc    (next_pc),
		.top_index  (top_index),
		.top_value  (top_value),
		.halted     (halted),
		.error_code (error_code)
	);

endmodule

`default_nettype wire

@@ verif/pcode_stack_machine_test.sv @@
`default_nettype none

module pcode_stack_machine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pcsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_WORDS = 1750;

	typedef struct {
		logic [PCW-1:0]        pc;
		logic [IDX_W-1:0]      idx;
		logic [WORD_WIDTH-1:0] val;
		logic                  halt;
		logic [ERR_W-1:0]      err;
	} step_result_t;

	// Machine state mirror and the queue of results still owed by the block.
	class pcsm_scoreboard;
		logic [WORD_WIDTH-1:0] stk [STACK_DEPTH];
		int unsigned tp;
		int unsigned fb;
		int unsigned pc;
		bit halt;
		step_result_t pending[$];

		function new();
			foreach (stk[i]) stk[i] = '0;
			tp = 0;
			fb = 1;
			pc = 0;
			halt = 0;
		endfunction

		// Follows up to MAX_LEVEL static links from the current frame.
		function bit walk_links(input logic [LEV_W-1:0] lev, output int unsigned base);
			logic [WORD_WIDTH-1:0] b1;
			int n;
			b1 = fb;
			n = (int'(lev) > MAX_LEVEL) ? MAX_LEVEL : int'(lev);
			base = 0;
			while (n > 0) begin
				if (b1 >= STACK_DEPTH) return 0;
				b1 = stk[b1[SAW-1:0]];
				if (b1 >= STACK_DEPTH) return 0;
				n--;
			end
			base = b1;
			return 1;
		endfunction

		function logic [WORD_WIDTH-1:0] quotient(input logic [WORD_WIDTH-1:0] x,
				input logic [WORD_WIDTH-1:0] y);
			logic [WORD_WIDTH-1:0] mx, my, q;
			mx = x[WORD_WIDTH-1] ? -x : x;
			my = y[WORD_WIDTH-1] ? -y : y;
			q = mx / my;
			if (x[WORD_WIDTH-1] ^ y[WORD_WIDTH-1]) q = -q;
			return q;
		endfunction

		// Executes one instruction on the mirror and queues the expected result.
		function void note_instruction(input logic [OPC_W-1:0] op, input logic [LEV_W-1:0] lev,
				input logic [OPD_W-1:0] a);
			int unsigned t, b, nxt, base, addr;
			logic [WORD_WIDTH-1:0] x, y, r, rb, rp;
			logic [ERR_W-1:0] err;
			step_result_t res;
			err = ERR_OK;
			if (!halt) begin
				t = tp;
				b = fb;
				nxt = (pc + 1) % CODE_DEPTH;
				case (op)
					OP_LIT: begin
						if (t + 1 >= STACK_DEPTH) err = ERR_STACK;
						else begin
							t++;
							stk[t] = WORD_WIDTH'(a);
						end
					end
					OP_OPR: begin
						if (a == OPR_RET) begin
							if (b == 0 || b + 2 >= STACK_DEPTH) err = ERR_STACK;
							else begin
								rb = stk[b + 1];
								rp = stk[b + 2];
								if (rb >= STACK_DEPTH) err = ERR_STACK;
								else begin
									t = b - 1;
									b = rb;
									nxt = rp % CODE_DEPTH;
								end
							end
						end else if (a == OPR_NEG) begin
							stk[t] = -stk[t];
						end else if (a == OPR_ODD) begin
							stk[t] = stk[t] & 1;
						end else if ((a >= OPR_ADD && a <= OPR_DIV) ||
								(a >= OPR_EQ && a <= OPR_LE)) begin
							if (t < 1) err = ERR_STACK;
							else begin
								x = stk[t - 1];
								y = stk[t];
								r = '0;
								case (a)
									OPR_ADD: r = x + y;
									OPR_SUB: r = x - y;
									OPR_MUL: r = x * y;
									OPR_DIV: begin
										if (y == 0) err = ERR_DIV0;
										else r = quotient(x, y);
									end
									OPR_EQ: r = WORD_WIDTH'(x == y);
									OPR_NE: r = WORD_WIDTH'(x != y);
									OPR_LT: r = WORD_WIDTH'($signed(x) < $signed(y));
									OPR_GE: r = WORD_WIDTH'(!($signed(x) < $signed(y)));
									OPR_GT: r = WORD_WIDTH'($signed(y) < $signed(x));
									default: r = WORD_WIDTH'(!($signed(y) < $signed(x)));
								endcase
								if (err == ERR_OK) begin
									t--;
									stk[t] = r;
								end
							end
						end else begin
							err = ERR_OPR;
						end
					end
					OP_LOD: begin
						if (!walk_links(lev, base)) err = ERR_STACK;
						else begin
							addr = base + a;
							if (addr >= STACK_DEPTH || t + 1 >= STACK_DEPTH) err = ERR_STACK;
							else begin
								r = stk[addr];
								t++;
								stk[t] = r;
							end
						end
					end
					OP_STO: begin
						if (!walk_links(lev, base)) err = ERR_STACK;
						else begin
							addr = base + a;
							if (addr >= STACK_DEPTH || t < 1) err = ERR_STACK;
							else begin
								stk[addr] = stk[t];
								t--;
							end
						end
					end
					OP_CAL: begin
						if (!walk_links(lev, base)) err = ERR_STACK;
						else if (t + 3 >= STACK_DEPTH) err = ERR_STACK;
						else begin
							stk[t + 1] = base;
							stk[t + 2] = b;
							stk[t + 3] = nxt;
							b = t + 1;
							nxt = a % CODE_DEPTH;
						end
					end
					OP_INT: begin
						if (t + a >= STACK_DEPTH) err = ERR_STACK;
						else t += a;
					end
					OP_JMP: nxt = a % CODE_DEPTH;
					default: begin
						if (t < 1) err = ERR_STACK;
						else begin
							if (stk[t] == 0) nxt = a % CODE_DEPTH;
							t--;
						end
					end
				endcase
				tp = t;
				fb = b;
				pc = nxt;
				halt = (nxt == 0);
			end
			res.pc = PCW'(pc);
			res.idx = IDX_W'(tp);
			res.val = stk[tp];
			res.halt = halt;
			res.err = err;
			pending.push_back(res);
		endfunction

		// Compares one result word with the oldest expectation.
		function bit check_result(input step_result_t got, output string msg);
			step_result_t want;
			msg = "";
			if (pending.size() == 0) begin
				msg = "result word with no instruction waiting";
				return 0;
			end
			want = pending.pop_front();
			if (got.pc !== want.pc)
				msg = {msg, $sformatf(" next_pc %0d/%0d", got.pc, want.pc)};
			if (got.idx !== want.idx)
				msg = {msg, $sformatf(" top_index %0d/%0d", got.idx, want.idx)};
			if (got.val !== want.val)
				msg = {msg, $sformatf(" top_value %h/%h", got.val, want.val)};
			if (got.halt !== want.halt)
				msg = {msg, $sformatf(" halted %b/%b", got.halt, want.halt)};
			if (got.err !== want.err)
				msg = {msg, $sformatf(" error_code %0d/%0d", got.err, want.err)};
			return msg == "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [OPC_W-1:0] opcode = '0;
	logic [LEV_W-1:0] level = '0;
	logic [OPD_W-1:0] operand = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [PCW-1:0] next_pc;
	logic [IDX_W-1:0] top_index;
	logic signed [WORD_WIDTH-1:0] top_value;
	logic halted;
	logic [ERR_W-1:0] error_code;

	pcsm_scoreboard sb = new();
	int mismatches = 0;
	int idle_cycles = 0;
	bit steady = 0;

	pcode_stack_machine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .level(level), .operand(operand),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .top_index(top_index), .top_value(top_value),
		.halted(halted), .error_code(error_code)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t:%s", $realtime, msg);
		mismatches++;
	endtask

	// Mostly short gaps, now and then a long one, none while steady is set.
	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Presents one instruction word and holds it until the block takes it.
	task automatic send_word(input logic [OPC_W-1:0] op, input logic [LEV_W-1:0] lev,
			input logic [OPD_W-1:0] opd);
		int gap;
		opcode = op;
		level = lev;
		operand = opd;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_instruction(op, lev, opd);
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// A target whose low byte is never zero, so that no jump halts the machine.
	function automatic logic [OPD_W-1:0] safe_target();
		return {3'($urandom_range(0, 7)), 8'($urandom_range(1, 239))};
	endfunction

	// Random instruction, mostly well formed against the mirrored state.
	task automatic random_word(output logic [OPC_W-1:0] op, output logic [LEV_W-1:0] lev,
			output logic [OPD_W-1:0] opd);
		int r;
		int unsigned b;
		lev = LEV_W'($urandom_range(0, 3));
		opd = OPD_W'($urandom_range(0, 2047));
		r = $urandom_range(0, 99);
		b = sb.fb;
		if (sb.pc >= 240) begin
			op = OP_JMP;
			opd = safe_target();
			return;
		end
		if (sb.tp > 450 && r < 70) begin
			op = OP_OPR;
			opd = OPR_ADD;
			return;
		end
		if (r < 22) begin
			op = OP_LIT;
		end else if (r < 52) begin
			op = OP_OPR;
			if ($urandom_range(0, 9) != 0) opd = OPD_W'($urandom_range(0, 13));
			if (opd == OPR_RET && b != 0 && b + 2 < STACK_DEPTH &&
					sb.stk[b + 1] < STACK_DEPTH && sb.stk[b + 2][7:0] == 0)
				opd = OPR_ADD;
		end else if (r < 64) begin
			op = OP_LOD;
			if ($urandom_range(0, 7) != 0) opd = OPD_W'($urandom_range(0, 8));
		end else if (r < 74) begin
			op = OP_STO;
			if ($urandom_range(0, 7) != 0) opd = OPD_W'($urandom_range(0, 8));
		end else if (r < 81) begin
			op = OP_CAL;
			opd = safe_target();
		end else if (r < 88) begin
			op = OP_INT;
			if ($urandom_range(0, 15) != 0) opd = OPD_W'($urandom_range(0, 8));
		end else if (r < 93) begin
			op = OP_JMP;
			opd = safe_target();
		end else begin
			op = OP_JPC;
			opd = safe_target();
		end
	endtask

	// Stimulus: directed words, random words, a drain pause, then a halt at the end.
	initial begin
		logic [OPC_W-1:0] op;
		logic [LEV_W-1:0] lev;
		logic [OPD_W-1:0] opd;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_word(OP_OPR, 0, OPR_ADD);
		send_word(OP_JPC, 0, 11'd10);
		send_word(OP_INT, 0, 11'd2047);
		send_word(OP_LIT, 0, 11'd2047);
		send_word(OP_LIT, 0, 11'd0);
		send_word(OP_OPR, 0, OPR_DIV);
		send_word(OP_OPR, 0, OPR_NEG);
		send_word(OP_LIT, 0, 11'd3);
		send_word(OP_OPR, 0, OPR_DIV);
		send_word(OP_OPR, 0, OPR_ODD);
		send_word(OP_OPR, 0, 11'd7);
		send_word(OP_OPR, 0, 11'd2047);
		send_word(OP_LIT, 0, 11'd5);
		send_word(OP_OPR, 0, OPR_EQ);
		send_word(OP_STO, 3, 11'd0);
		send_word(OP_LOD, 3, 11'd2047);
		send_word(OP_CAL, 0, 11'd100);
		send_word(OP_INT, 0, 11'd3);
		send_word(OP_LOD, 1, 11'd1);
		send_word(OP_OPR, 0, OPR_RET);
		send_word(OP_LIT, 0, 11'd1024);
		send_word(OP_OPR, 0, OPR_MUL);
		send_word(OP_JPC, 0, 11'd200);
		send_word(OP_INT, 0, 11'd509);
		send_word(OP_LIT, 0, 11'd1);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady = (i >= 600 && i < 800);
			if (i == 900) begin
				in_valid = 0;
				wait (sb.pending.size() == 0);
				@(negedge clk);
			end
			random_word(op, lev, opd);
			send_word(op, lev, opd);
		end
		// A jump to address zero halts; later words only report the state.
		send_word(OP_JMP, 0, 11'd256);
		for (int i = 0; i < 4; i++) begin
			random_word(op, lev, opd);
			send_word(op, lev, opd);
		end
		in_valid = 0;
		wait (sb.pending.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("pcode_stack_machine_test OK");
		else
			$display("pcode_stack_machine_test NOT OK");
		$finish;
	end

	// Result side: random stalls, with steady stretches and a few long ones.
	initial begin
		int stall;
		step_result_t got;
		string msg;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.pc = next_pc;
				got.idx = top_index;
				got.val = top_value;
				got.halt = halted;
				got.err = error_code;
				if (!sb.check_result(got, msg)) report_mismatch(msg);
			end
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ready = 0;
			end else if (steady) begin
				out_ready = 1;
			end else begin
				case ($urandom_range(0, 19))
					0: stall = $urandom_range(10, 40);
					1, 2, 3, 4: stall = $urandom_range(1, 3);
					default: stall = 0;
				endcase
				out_ready = (stall == 0);
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("pcode_stack_machine_test NOT OK");
			$finish;
		end
	end

endmodule

`default_nettype wire

@@ pcode_stack_machine.f @@
src/pcsm_pkg.sv
src/pcsm_div.sv
src/pcsm_ctrl.sv
src/pcsm_dp.sv
src/pcode_stack_machine.sv
verif/pcode_stack_machine_test.sv
